// ===== src/ccr_pkg.sv =====
`timescale 1ns / 1ps
// shared request and response types and saturation helper for the circle collision block
package ccr_pkg;

    localparam int POS_W  = 32;
    localparam int MASS_W = 16;
    localparam int REACH_W = 24;
    localparam int SAT_W  = 40;

    typedef struct packed {
        logic signed [POS_W-1:0] first_pos_x;
        logic signed [POS_W-1:0] first_pos_y;
        logic signed [POS_W-1:0] second_pos_x;
        logic signed [POS_W-1:0] second_pos_y;
        logic signed [POS_W-1:0] first_vel_x;
        logic signed [POS_W-1:0] first_vel_y;
        logic signed [POS_W-1:0] second_vel_x;
        logic signed [POS_W-1:0] second_vel_y;
        logic [MASS_W-1:0]       first_mass;
        logic [MASS_W-1:0]       second_mass;
        logic [REACH_W-1:0]      contact_reach;
        logic [1:0]              movable_mask;
    } t_req;

    typedef struct packed {
        logic                    collided;
        logic signed [POS_W-1:0] new_first_pos_x;
        logic signed [POS_W-1:0] new_first_pos_y;
        logic signed [POS_W-1:0] new_second_pos_x;
        logic signed [POS_W-1:0] new_second_pos_y;
        logic signed [POS_W-1:0] new_first_vel_x;
        logic signed [POS_W-1:0] new_first_vel_y;
        logic signed [POS_W-1:0] new_second_vel_x;
        logic signed [POS_W-1:0] new_second_vel_y;
    } t_resp;

    function automatic logic signed [POS_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
        logic fits;
        fits = (&v[SAT_W-1:POS_W-1]) || !(|v[SAT_W-1:POS_W-1]);
        if (fits) begin
            sat_word = v[POS_W-1:0];
        end else if (v[SAT_W-1]) begin
            sat_word = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            sat_word = {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== src/ccr_delay.sv =====
`timescale 1ns / 1ps
// stallable delay line for valid bits and side data
module ccr_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [DEPTH-1:0] r_valid;
    logic [W-1:0]     r_data [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

// ===== src/ccr_isqrt.sv =====
`timescale 1ns / 1ps
// pipelined integer square root, one result bit per stage
module ccr_isqrt #(
    parameter int IN_W = 50
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [IN_W-1:0]     i_rad,
    output logic [IN_W/2-1:0]   o_root
);

    localparam int OUT_W = IN_W / 2;

    logic [OUT_W+1:0] r_rem  [OUT_W-1];
    logic [IN_W-1:0]  r_x    [OUT_W-1];
    logic [OUT_W-1:0] r_root [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_step
        logic [OUT_W+1:0] p_rem;
        logic [OUT_W+1:0] t_rem;
        logic [OUT_W+1:0] trial;
        logic [OUT_W+1:0] n_rem;
        logic [OUT_W-1:0] p_root;
        logic [OUT_W-1:0] n_root;
        logic [IN_W-1:0]  p_x;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_rad;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_x    = r_x[k-1];
        end

        assign t_rem = {p_rem[OUT_W-1:0], p_x[IN_W-1 -: 2]};
        assign trial = {p_root, 2'b01};

        always_comb begin
            if (t_rem >= trial) begin
                n_rem  = t_rem - trial;
                n_root = {p_root[OUT_W-2:0], 1'b1};
            end else begin
                n_rem  = t_rem;
                n_root = {p_root[OUT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= n_root;
            end
        end

        if (k < OUT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_x[k]   <= {p_x[IN_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[OUT_W-1];

endmodule

// ===== src/ccr_div.sv =====
`timescale 1ns / 1ps
// pipelined signed by unsigned divider, truncating, one quotient bit per stage
module ccr_div #(
    parameter int NUM_W = 59,
    parameter int DEN_W = 24,
    parameter int QUO_W = 34
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic signed [QUO_W:0]   o_quo
);

    localparam int WIDE_W = NUM_W + DEN_W;

    logic [NUM_W-1:0]      r_mag;
    logic [DEN_W-1:0]      r_den0;
    logic                  r_neg0;
    logic [WIDE_W-1:0]     init_wide;
    logic [DEN_W-1:0]      r_rem [QUO_W-1];
    logic [DEN_W-1:0]      r_den [QUO_W-1];
    logic [QUO_W-1:0]      r_low [QUO_W];
    logic                  r_neg [QUO_W];
    logic signed [QUO_W:0] r_quo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag  <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_den0 <= i_den;
            r_neg0 <= i_num[NUM_W-1];
        end
    end

    assign init_wide = WIDE_W'(r_mag) >> QUO_W;

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W-1:0] p_rem;
        logic [DEN_W-1:0] p_den;
        logic [QUO_W-1:0] p_low;
        logic             p_neg;
        logic [DEN_W:0]   t_rem;
        logic             ge;

        if (k == 0) begin : g_first
            assign p_rem = init_wide[DEN_W-1:0];
            assign p_den = r_den0;
            assign p_low = r_mag[QUO_W-1:0];
            assign p_neg = r_neg0;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_den = r_den[k-1];
            assign p_low = r_low[k-1];
            assign p_neg = r_neg[k-1];
        end

        assign t_rem = {p_rem, p_low[QUO_W-1]};
        assign ge    = t_rem >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_low[k] <= {p_low[QUO_W-2:0], ge};
                r_neg[k] <= p_neg;
            end
        end

        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? DEN_W'(t_rem - {1'b0, p_den}) : t_rem[DEN_W-1:0];
                    r_den[k] <= p_den;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= r_neg[QUO_W-1] ? -$signed({1'b0, r_low[QUO_W-1]})
                                    : $signed({1'b0, r_low[QUO_W-1]});
        end
    end

    assign o_quo = r_quo;

endmodule

// ===== src/circle_collision_response.sv =====
`timescale 1ns / 1ps
// top level: circle pair contact test and impulse response pipeline
// Takes one body pair per clock while o_stall is low and returns one response per request,
// in order, on o_valid. The path from request to response is set by the chain of
// bit-per-stage units on the critical path: the 25-stage square root, the normal-speed
// divider, the impulse divider and the per-axis velocity divider. A two-entry output
// register (main plus skid) keeps requests flowing while a response waits; o_stall rises
// only when both entries are full.
module circle_collision_response
    import ccr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_req  i_req,
    output logic  o_valid,
    input  logic  i_stall,
    output t_resp o_resp
);

    localparam int DX_W     = 25;
    localparam int RV_W     = 33;
    localparam int DOT_W    = 59;
    localparam int D2_W     = 50;
    localparam int RR_W     = 2 * REACH_W;
    localparam int DIST_W   = 24;
    localparam int SQ_LAT   = D2_W / 2;
    localparam int VN_Q     = 34;
    localparam int VN_LAT   = VN_Q + 2;
    localparam int OV_NUM_W = 50;
    localparam int OV_Q     = VN_Q - 2;
    localparam int MSUM_W   = MASS_W + 1;
    localparam int J_NUM_W  = 52;
    localparam int J_Q      = 35;
    localparam int J_LAT    = J_Q + 2;
    localparam int JD_NUM_W = 61;
    localparam int JD_Q     = 36;
    localparam int JD_LAT   = JD_Q + 2;

    typedef struct packed {
        t_req                    req;
        logic                    contact;
        logic signed [DOT_W-1:0] dot;
        logic signed [DX_W-1:0]  dx;
        logic signed [DX_W-1:0]  dy;
    } t_sb1;

    typedef struct packed {
        t_req                   req;
        logic                   contact;
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] dy;
        logic [DIST_W-1:0]      dlen;
    } t_sb2;

    typedef struct packed {
        t_req                   req;
        logic                   contact;
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] dy;
        logic [DIST_W-1:0]      dlen;
        logic signed [OV_Q:0]   ox;
        logic signed [OV_Q:0]   oy;
    } t_sb3;

    typedef struct packed {
        t_req                 req;
        logic                 contact;
        logic signed [OV_Q:0] ox;
        logic signed [OV_Q:0] oy;
    } t_sb4;

    logic en;

    // output main and skid registers
    logic  r_ov;
    logic  r_skid_v;
    t_resp r_resp;
    t_resp r_skid;

    assign en = !r_skid_v;

    // stage 1: capture
    logic r1_v;
    t_req r1_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_req <= i_req;
        end
    end

    // stage 2: differences and box pretest
    logic signed [RV_W-1:0] n2_dx, n2_dy, n2_adx, n2_ady, n2_reach;
    logic                   r2_v;
    t_req                   r2_req;
    logic signed [DX_W-1:0] r2_dx, r2_dy;
    logic signed [RV_W-1:0] r2_rvx, r2_rvy;
    logic                   r2_pre;

    assign n2_dx    = RV_W'(r1_req.second_pos_x) - RV_W'(r1_req.first_pos_x);
    assign n2_dy    = RV_W'(r1_req.second_pos_y) - RV_W'(r1_req.first_pos_y);
    assign n2_adx   = n2_dx[RV_W-1] ? -n2_dx : n2_dx;
    assign n2_ady   = n2_dy[RV_W-1] ? -n2_dy : n2_dy;
    assign n2_reach = $signed(RV_W'(r1_req.contact_reach));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_req <= r1_req;
            r2_dx  <= n2_dx[DX_W-1:0];
            r2_dy  <= n2_dy[DX_W-1:0];
            r2_rvx <= RV_W'(r1_req.second_vel_x) - RV_W'(r1_req.first_vel_x);
            r2_rvy <= RV_W'(r1_req.second_vel_y) - RV_W'(r1_req.first_vel_y);
            r2_pre <= (n2_adx < n2_reach) && (n2_ady < n2_reach);
        end
    end

    // stage 3: products
    logic                    r3_v;
    t_req                    r3_req;
    logic signed [DX_W-1:0]  r3_dx, r3_dy;
    logic                    r3_pre;
    logic [D2_W-1:0]         r3_dx2, r3_dy2;
    logic signed [DOT_W-2:0] r3_dotx, r3_doty;
    logic [RR_W-1:0]         r3_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_req  <= r2_req;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_pre  <= r2_pre;
            r3_dx2  <= r2_dx * r2_dx;
            r3_dy2  <= r2_dy * r2_dy;
            r3_dotx <= r2_rvx * r2_dx;
            r3_doty <= r2_rvy * r2_dy;
            r3_rr   <= r2_req.contact_reach * r2_req.contact_reach;
        end
    end

    // stage 4: squared distance, contact decision, dot product
    logic [D2_W-1:0] n4_d2;
    t_sb1            n4_sb;
    logic            r4_v;
    logic [D2_W-1:0] r4_d2;
    t_sb1            r4_sb;

    assign n4_d2 = r3_dx2 + r3_dy2;

    always_comb begin
        n4_sb.req     = r3_req;
        n4_sb.contact = r3_pre && (n4_d2 != '0) && (n4_d2 < D2_W'(r3_rr));
        n4_sb.dot     = DOT_W'(r3_dotx) + DOT_W'(r3_doty);
        n4_sb.dx      = r3_dx;
        n4_sb.dy      = r3_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_d2 <= n4_d2;
            r4_sb <= n4_sb;
        end
    end

    // distance
    logic [D2_W/2-1:0] s_root;
    logic [DIST_W-1:0] s_dist;
    logic              s1_v;
    t_sb1              s1_sb;

    ccr_isqrt #(.IN_W(D2_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r4_d2),
        .o_root (s_root)
    );

    ccr_delay #(.W($bits(t_sb1)), .DEPTH(SQ_LAT)) u_seg1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_data  (r4_sb),
        .o_valid (s1_v),
        .o_data  (s1_sb)
    );

    assign s_dist = s_root[DIST_W-1:0];

    // normal speed and overlap push
    logic signed [VN_Q:0]     b_vn;
    logic [DIST_W-1:0]        ra_ov, ra_dist, rb_dist;
    logic signed [DX_W-1:0]   ra_dx, ra_dy;
    logic signed [OV_NUM_W-1:0] rb_ovx, rb_ovy;
    logic signed [OV_Q:0]     b_ox, b_oy;
    t_sb2                     n_s2;
    logic                     b_v;
    t_sb2                     b_sb;

    ccr_div #(.NUM_W(DOT_W), .DEN_W(DIST_W), .QUO_W(VN_Q)) u_div_vn (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (s1_sb.dot),
        .i_den (s_dist),
        .o_quo (b_vn)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_ov   <= s1_sb.req.contact_reach - s_dist;
            ra_dist <= s_dist;
            ra_dx   <= s1_sb.dx;
            ra_dy   <= s1_sb.dy;
            rb_ovx  <= $signed({1'b0, ra_ov}) * ra_dx;
            rb_ovy  <= $signed({1'b0, ra_ov}) * ra_dy;
            rb_dist <= ra_dist;
        end
    end

    ccr_div #(.NUM_W(OV_NUM_W), .DEN_W(DIST_W), .QUO_W(OV_Q)) u_div_ox (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (rb_ovx),
        .i_den (rb_dist),
        .o_quo (b_ox)
    );

    ccr_div #(.NUM_W(OV_NUM_W), .DEN_W(DIST_W), .QUO_W(OV_Q)) u_div_oy (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (rb_ovy),
        .i_den (rb_dist),
        .o_quo (b_oy)
    );

    always_comb begin
        n_s2.req     = s1_sb.req;
        n_s2.contact = s1_sb.contact;
        n_s2.dx      = s1_sb.dx;
        n_s2.dy      = s1_sb.dy;
        n_s2.dlen    = s_dist;
    end

    ccr_delay #(.W($bits(t_sb2)), .DEPTH(VN_LAT)) u_seg2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_v),
        .i_data  (n_s2),
        .o_valid (b_v),
        .o_data  (b_sb)
    );

    // impulse per body
    logic signed [J_NUM_W-1:0] rc_ja_num, rc_jb_num;
    logic [MSUM_W-1:0]         rc_msum;
    logic signed [J_Q:0]       c_ja, c_jb, c_ja_z, c_jb_z;
    logic                      c_mzero;
    t_sb3                      n_s3;
    logic                      c_v;
    t_sb3                      c_sb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc_ja_num <= $signed({1'b0, b_sb.req.second_mass, 1'b0}) * b_vn;
            rc_jb_num <= $signed({1'b0, b_sb.req.first_mass, 1'b0}) * b_vn;
            rc_msum   <= MSUM_W'(b_sb.req.first_mass) + MSUM_W'(b_sb.req.second_mass);
        end
    end

    ccr_div #(.NUM_W(J_NUM_W), .DEN_W(MSUM_W), .QUO_W(J_Q)) u_div_ja (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (rc_ja_num),
        .i_den (rc_msum),
        .o_quo (c_ja)
    );

    ccr_div #(.NUM_W(J_NUM_W), .DEN_W(MSUM_W), .QUO_W(J_Q)) u_div_jb (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (rc_jb_num),
        .i_den (rc_msum),
        .o_quo (c_jb)
    );

    always_comb begin
        n_s3.req     = b_sb.req;
        n_s3.contact = b_sb.contact;
        n_s3.dx      = b_sb.dx;
        n_s3.dy      = b_sb.dy;
        n_s3.dlen    = b_sb.dlen;
        n_s3.ox      = b_ox;
        n_s3.oy      = b_oy;
    end

    ccr_delay #(.W($bits(t_sb3)), .DEPTH(J_LAT + 1)) u_seg3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (b_v),
        .i_data  (n_s3),
        .o_valid (c_v),
        .o_data  (c_sb)
    );

    // both masses zero gives no impulse
    assign c_mzero = (c_sb.req.first_mass == '0) && (c_sb.req.second_mass == '0);
    assign c_ja_z  = c_mzero ? '0 : c_ja;
    assign c_jb_z  = c_mzero ? '0 : c_jb;

    // velocity change per axis
    logic signed [JD_NUM_W-1:0] rd_jax, rd_jay, rd_jbx, rd_jby;
    logic [DIST_W-1:0]          rd_dist;
    logic signed [JD_Q:0]       d_qax, d_qay, d_qbx, d_qby;
    t_sb4                       n_s4;
    logic                       d_v;
    t_sb4                       d_sb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            rd_jax  <= c_ja_z * c_sb.dx;
            rd_jay  <= c_ja_z * c_sb.dy;
            rd_jbx  <= c_jb_z * c_sb.dx;
            rd_jby  <= c_jb_z * c_sb.dy;
            rd_dist <= c_sb.dlen;
        end
    end

    ccr_div #(.NUM_W(JD_NUM_W), .DEN_W(DIST_W), .QUO_W(JD_Q)) u_div_qax (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (rd_jax),
        .i_den (rd_dist),
        .o_quo (d_qax)
    );

    ccr_div #(.NUM_W(JD_NUM_W), .DEN_W(DIST_W), .QUO_W(JD_Q)) u_div_qay (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (rd_jay),
        .i_den (rd_dist),
        .o_quo (d_qay)
    );

    ccr_div #(.NUM_W(JD_NUM_W), .DEN_W(DIST_W), .QUO_W(JD_Q)) u_div_qbx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (rd_jbx),
        .i_den (rd_dist),
        .o_quo (d_qbx)
    );

    ccr_div #(.NUM_W(JD_NUM_W), .DEN_W(DIST_W), .QUO_W(JD_Q)) u_div_qby (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (rd_jby),
        .i_den (rd_dist),
        .o_quo (d_qby)
    );

    always_comb begin
        n_s4.req     = c_sb.req;
        n_s4.contact = c_sb.contact;
        n_s4.ox      = c_sb.ox;
        n_s4.oy      = c_sb.oy;
    end

    ccr_delay #(.W($bits(t_sb4)), .DEPTH(JD_LAT + 1)) u_seg4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_v),
        .i_data  (n_s4),
        .o_valid (d_v),
        .o_data  (d_sb)
    );

    // final update with saturation
    t_req  f_req;
    t_resp f_resp;

    assign f_req = d_sb.req;

    always_comb begin
        f_resp.collided         = d_sb.contact;
        f_resp.new_first_pos_x  = f_req.first_pos_x;
        f_resp.new_first_pos_y  = f_req.first_pos_y;
        f_resp.new_second_pos_x = f_req.second_pos_x;
        f_resp.new_second_pos_y = f_req.second_pos_y;
        f_resp.new_first_vel_x  = f_req.first_vel_x;
        f_resp.new_first_vel_y  = f_req.first_vel_y;
        f_resp.new_second_vel_x = f_req.second_vel_x;
        f_resp.new_second_vel_y = f_req.second_vel_y;
        if (d_sb.contact) begin
            if (f_req.movable_mask[0]) begin
                f_resp.new_first_pos_x = sat_word(SAT_W'(f_req.first_pos_x) - SAT_W'(d_sb.ox));
                f_resp.new_first_pos_y = sat_word(SAT_W'(f_req.first_pos_y) - SAT_W'(d_sb.oy));
                f_resp.new_first_vel_x = sat_word(SAT_W'(f_req.first_vel_x) + SAT_W'(d_qax));
                f_resp.new_first_vel_y = sat_word(SAT_W'(f_req.first_vel_y) + SAT_W'(d_qay));
            end
            if (f_req.movable_mask[1]) begin
                f_resp.new_second_pos_x = sat_word(SAT_W'(f_req.second_pos_x) + SAT_W'(d_sb.ox));
                f_resp.new_second_pos_y = sat_word(SAT_W'(f_req.second_pos_y) + SAT_W'(d_sb.oy));
                f_resp.new_second_vel_x = sat_word(SAT_W'(f_req.second_vel_x) - SAT_W'(d_qbx));
                f_resp.new_second_vel_y = sat_word(SAT_W'(f_req.second_vel_y) - SAT_W'(d_qby));
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_resp   <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (!r_ov || !i_stall) begin
            r_ov   <= d_v;
            r_resp <= f_resp;
        end else if (d_v) begin
            r_skid   <= f_resp;
            r_skid_v <= 1'b1;
        end
    end

    assign o_valid = r_ov;
    assign o_resp  = r_resp;
    assign o_stall = r_skid_v;

endmodule

// ===== src/ccr_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the circle collision block and its bind
module ccr_checker
    import ccr_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_valid,
    input logic  o_stall,
    input t_req  i_req,
    input logic  o_valid,
    input logic  i_stall,
    input t_resp o_resp
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("response dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_resp))
        else $error("response changed while stalled");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("request stall without a pending response");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("request stall rose without a stalled response");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs active after reset");

endmodule

bind circle_collision_response ccr_checker u_ccr_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for circle_collision_response: random and directed body pairs checked in order
module tb_top;
    import ccr_pkg::*;

    localparam int TIMEOUT_CYCLES = 20000;
    localparam int DRAIN_CYCLES   = 400;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_req  i_req;
    logic  o_valid;
    logic  i_stall;
    t_resp o_resp;

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    int    n_fail;
    int    n_sent;
    int    n_total;
    int    stall_cnt;
    bit    stim_done;

    circle_collision_response i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_resp  (o_resp)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint trunc_div(longint num, longint den);
        if (den == 0) begin
            return 0;
        end
        return num / den;
    endfunction

    function automatic longint floor_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_resp resolve_pair(t_req r);
        t_resp  res;
        longint pax, pay, pbx, pby, vax, vay, vbx, vby;
        longint ma, mb, reach, dx, dy, d2, dlen, vn, ja, jb, ov, ox, oy, msum;
        bit     hit;
        pax = longint'(r.first_pos_x);
        pay = longint'(r.first_pos_y);
        pbx = longint'(r.second_pos_x);
        pby = longint'(r.second_pos_y);
        vax = longint'(r.first_vel_x);
        vay = longint'(r.first_vel_y);
        vbx = longint'(r.second_vel_x);
        vby = longint'(r.second_vel_y);
        ma    = longint'({48'd0, r.first_mass});
        mb    = longint'({48'd0, r.second_mass});
        reach = longint'({40'd0, r.contact_reach});
        dx = pbx - pax;
        dy = pby - pay;
        hit = 1'b0;
        if ((dx < 0 ? -dx : dx) < reach && (dy < 0 ? -dy : dy) < reach) begin
            d2 = dx * dx + dy * dy;
            if (d2 != 0 && d2 < reach * reach) begin
                hit  = 1'b1;
                dlen = floor_sqrt(d2);
                vn   = trunc_div((vbx - vax) * dx + (vby - vay) * dy, dlen);
                msum = ma + mb;
                ov   = reach - dlen;
                ox   = trunc_div(ov * dx, dlen);
                oy   = trunc_div(ov * dy, dlen);
                ja   = trunc_div(2 * mb * vn, msum);
                jb   = trunc_div(2 * ma * vn, msum);
                if (r.movable_mask[0]) begin
                    vax += trunc_div(ja * dx, dlen);
                    vay += trunc_div(ja * dy, dlen);
                    pax -= ox;
                    pay -= oy;
                end
                if (r.movable_mask[1]) begin
                    vbx -= trunc_div(jb * dx, dlen);
                    vby -= trunc_div(jb * dy, dlen);
                    pbx += ox;
                    pby += oy;
                end
            end
        end
        res.collided         = hit;
        res.new_first_pos_x  = clamp32(pax);
        res.new_first_pos_y  = clamp32(pay);
        res.new_second_pos_x = clamp32(pbx);
        res.new_second_pos_y = clamp32(pby);
        res.new_first_vel_x  = clamp32(vax);
        res.new_first_vel_y  = clamp32(vay);
        res.new_second_vel_x = clamp32(vbx);
        res.new_second_vel_y = clamp32(vby);
        return res;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 2000)) - 32'sd1000;
            1: return $urandom_range(0, 1) ? 32'sh7fffff00 + 32'($urandom_range(0, 255))
                                             : 32'sh80000000 + 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_mass();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(1, 16));
            1: return 16'($urandom_range(65520, 65535));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // second centre placed so each axis offset is under the contact reach
    function automatic t_req touching_pair();
        t_req   r;
        longint reach, dx, dy, bx, by;
        r.first_pos_x  = rand_word();
        r.first_pos_y  = rand_word();
        r.first_vel_x  = rand_word();
        r.first_vel_y  = rand_word();
        r.second_vel_x = rand_word();
        r.second_vel_y = rand_word();
        r.first_mass   = rand_mass();
        r.second_mass  = rand_mass();
        r.movable_mask = 2'($urandom_range(0, 3));
        reach = $urandom_range(0, 7) == 0 ? $urandom_range(2, 24'hffffff)
                                          : $urandom_range(2, 4096);
        r.contact_reach = 24'(reach);
        dx = longint'($urandom_range(0, 2 * reach - 2)) - (reach - 1);
        dy = longint'($urandom_range(0, 2 * reach - 2)) - (reach - 1);
        if ($urandom_range(0, 3) == 0) begin
            dx = dx / 2;
            dy = dy / 2;
        end
        bx = longint'(r.first_pos_x) + dx;
        by = longint'(r.first_pos_y) + dy;
        if (bx > 64'sd2147483647 || bx < -64'sd2147483648) begin
            bx = longint'(r.first_pos_x) - dx;
        end
        if (by > 64'sd2147483647 || by < -64'sd2147483648) begin
            by = longint'(r.first_pos_y) - dy;
        end
        r.second_pos_x = bx[31:0];
        r.second_pos_y = by[31:0];
        return r;
    endfunction

    function automatic t_req noise_pair();
        t_req              r;
        logic [11*32-1:0]  raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(t_req)-1:0];
        if (r.first_mass == 0) r.first_mass = 16'd1;
        if (r.second_mass == 0) r.second_mass = 16'd1;
        return r;
    endfunction

    function automatic int sender_idle_pct();
        if (n_sent < n_total / 3) return 16;
        if (n_sent < 2 * n_total / 3) return 82;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_sent < n_total / 3) return 82;
        if (n_sent < 2 * n_total / 3) return 16;
        return 0;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                expected_resps.push_back(resolve_pair(i_req));
                n_sent++;
            end
            if (pending_reqs.size() > 0 && $urandom_range(1, 100) > sender_idle_pct()) begin
                i_req   <= pending_reqs.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_resp exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_resps.size() == 0) begin
                    $error("response with nothing expected");
                    n_fail++;
                end else begin
                    exp_r = expected_resps.pop_front();
                    if (o_resp.collided !== exp_r.collided) begin
                        $error("collided exp %0d got %0d", exp_r.collided, o_resp.collided);
                        n_fail++;
                    end
                    if (o_resp.new_first_pos_x !== exp_r.new_first_pos_x) begin
                        $error("new_first_pos_x exp %0d got %0d",
                               exp_r.new_first_pos_x, o_resp.new_first_pos_x);
                        n_fail++;
                    end
                    if (o_resp.new_first_pos_y !== exp_r.new_first_pos_y) begin
                        $error("new_first_pos_y exp %0d got %0d",
                               exp_r.new_first_pos_y, o_resp.new_first_pos_y);
                        n_fail++;
                    end
                    if (o_resp.new_second_pos_x !== exp_r.new_second_pos_x) begin
                        $error("new_second_pos_x exp %0d got %0d",
                               exp_r.new_second_pos_x, o_resp.new_second_pos_x);
                        n_fail++;
                    end
                    if (o_resp.new_second_pos_y !== exp_r.new_second_pos_y) begin
                        $error("new_second_pos_y exp %0d got %0d",
                               exp_r.new_second_pos_y, o_resp.new_second_pos_y);
                        n_fail++;
                    end
                    if (o_resp.new_first_vel_x !== exp_r.new_first_vel_x) begin
                        $error("new_first_vel_x exp %0d got %0d",
                               exp_r.new_first_vel_x, o_resp.new_first_vel_x);
                        n_fail++;
                    end
                    if (o_resp.new_first_vel_y !== exp_r.new_first_vel_y) begin
                        $error("new_first_vel_y exp %0d got %0d",
                               exp_r.new_first_vel_y, o_resp.new_first_vel_y);
                        n_fail++;
                    end
                    if (o_resp.new_second_vel_x !== exp_r.new_second_vel_x) begin
                        $error("new_second_vel_x exp %0d got %0d",
                               exp_r.new_second_vel_x, o_resp.new_second_vel_x);
                        n_fail++;
                    end
                    if (o_resp.new_second_vel_y !== exp_r.new_second_vel_y) begin
                        $error("new_second_vel_y exp %0d got %0d",
                               exp_r.new_second_vel_y, o_resp.new_second_vel_y);
                        n_fail++;
                    end
                end
            end
            i_stall <= ($urandom_range(1, 100) <= receiver_idle_pct());
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || stim_done) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= TIMEOUT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        t_req base;
        t_req r;
        n_fail    = 0;
        n_sent    = 0;
        stall_cnt = 0;
        stim_done = 1'b0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_stall   = 1'b0;
        i_req     = '0;

        // head-on pair along x, both movable
        base = '0;
        base.first_pos_x   = 32'sd0;
        base.second_pos_x  = 32'sd256;
        base.first_vel_x   = 32'sd512;
        base.second_vel_x  = -32'sd512;
        base.first_mass    = 16'd256;
        base.second_mass   = 16'd256;
        base.contact_reach = 24'd512;
        base.movable_mask  = 2'b11;
        pending_reqs.push_back(base);
        for (int m = 0; m < 3; m++) begin
            r = base;
            r.movable_mask = 2'(m);
            pending_reqs.push_back(r);
        end
        // no contact, zero reach, touching exactly, coincident centres
        r = base; r.second_pos_x = 32'sd5000;            pending_reqs.push_back(r);
        r = base; r.contact_reach = 24'd0;               pending_reqs.push_back(r);
        r = base; r.contact_reach = 24'd256;             pending_reqs.push_back(r);
        r = base; r.second_pos_x = 32'sd0;               pending_reqs.push_back(r);
        // mass extremes
        r = base; r.first_mass = 16'd1; r.second_mass = 16'd65535; pending_reqs.push_back(r);
        r = base; r.first_mass = 16'd65535; r.second_mass = 16'd1; pending_reqs.push_back(r);
        // separating bodies
        r = base; r.first_vel_x = -32'sd700; r.second_vel_x = 32'sd900; pending_reqs.push_back(r);
        // max reach, diagonal offset
        r = base; r.contact_reach = 24'hffffff; r.second_pos_x = 32'sd3000000;
        r.second_pos_y = -32'sd4000000; pending_reqs.push_back(r);
        // saturation at the positive and negative edges
        r = base; r.contact_reach = 24'hffffff;
        r.first_pos_x = 32'sh80000000; r.second_pos_x = 32'sh80000010;
        r.first_vel_x = 32'sh7fffffff; r.second_vel_x = 32'sh80000000; pending_reqs.push_back(r);
        r = base; r.contact_reach = 24'hffffff;
        r.first_pos_x = 32'sh7ffffff0; r.second_pos_x = 32'sh7fffffff;
        r.first_vel_x = 32'sh80000000; r.second_vel_x = 32'sh7fffffff; pending_reqs.push_back(r);
        r = base; r.first_pos_y = 32'sh7fffff00; r.second_pos_y = 32'sh7fffff80;
        r.second_pos_x = 32'sd0; r.first_vel_y = 32'sh7fffffff; r.second_vel_y = 32'sh80000000;
        pending_reqs.push_back(r);
        // all-ones and all-zeros fields
        r = t_req'('1); pending_reqs.push_back(r);
        r = '0; r.first_mass = 16'd1; r.second_mass = 16'd1; pending_reqs.push_back(r);

        for (int k = 0; k < 1250; k++) begin
            pending_reqs.push_back($urandom_range(0, 9) < 8 ? touching_pair() : noise_pair());
        end
        n_total = pending_reqs.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && n_sent == n_total && expected_resps.size() == 0);
        stim_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0 && expected_resps.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
